// ----- rtl/core/wms_pkg.sv -----
// Shared constants, types and pattern helpers for the wiki markup stripper.
`default_nettype none
package wms_pkg;

	localparam int LOOKAHEAD = 18;
	localparam int CNT_W = 5;
	localparam int DEPTH_W = 8;
	localparam int LIMIT_W = 16;
	localparam int NLITS = 39;
	localparam int LIT_W = LOOKAHEAD * 8;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2000;

	localparam logic [2:0] M_NORMAL = 3'd0;
	localparam logic [2:0] M_BRACE = 3'd1;
	localparam logic [2:0] M_MATH = 3'd2;
	localparam logic [2:0] M_FONT = 3'd3;
	localparam logic [2:0] M_GT = 3'd4;
	localparam logic [2:0] M_CAT = 3'd5;
	localparam logic [2:0] M_TRUNC = 3'd6;

	typedef logic [LOOKAHEAD-1:0][7:0] window_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} item_t;

	typedef struct packed {
		logic math;
		logic font;
		logic ref_tag;
		logic cat;
		logic div_tag;
		logic lit;
		logic [CNT_W-1:0] lit_len;
		logic drop;
		logic [2:0] utf8_len;
		logic close_math;
		logic close_font;
		logic close_cat;
	} match_t;

	localparam logic [LIT_W-1:0] LIT_STR [NLITS] = '{
		"<ul>", "<li>", "<em>", "</ul>", "</li>", "</em>", "[[", "]]",
		"<small>", "</small>", "<br>", "<br >", "<br />", "<BR>", "<br/>",
		"</br/>", "<br/ >", "<ref>", "</ref>", "<code>", "</code>",
		"<table alignright>", "</table>", "<tt>", "</tt>", "<sup>", "</sup>",
		"<nowiki>", "</nowiki>", "<HR>", "<!--", "-->", "<REF>", "</REF>",
		"<center>", "</center>", "&amp;", "</div>", "</DIV>"
	};

	localparam logic [CNT_W-1:0] LIT_LEN [NLITS] = '{
		5'd4, 5'd4, 5'd4, 5'd5, 5'd5, 5'd5, 5'd2, 5'd2,
		5'd7, 5'd8, 5'd4, 5'd5, 5'd6, 5'd4, 5'd5,
		5'd6, 5'd6, 5'd5, 5'd6, 5'd6, 5'd7,
		5'd18, 5'd8, 5'd4, 5'd5, 5'd5, 5'd6,
		5'd8, 5'd9, 5'd4, 5'd4, 5'd3, 5'd5, 5'd6,
		5'd8, 5'd9, 5'd5, 5'd6, 5'd6
	};

	// True when the window head spells s; a string is right-justified in s.
	function automatic logic head_is(window_t w, logic [CNT_W-1:0] cnt,
			logic [LIT_W-1:0] s, logic [CNT_W-1:0] len);
		logic ok;
		int pos;
		ok = 1'b1;
		for (int i = 0; i < LOOKAHEAD; i++) begin
			if (i < int'(len)) begin
				pos = (int'(len) - 1 - i) * 8;
				if (i >= int'(cnt) || w[i] != s[pos +: 8]) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wiki_markup_stripper.sv -----
// Top level of the wiki markup stripper.
//
// Takes one text byte per word and returns the cleaned text: newlines become
// periods; brace groups, math and font blocks, ref and div tags, category
// links and a fixed set of tags are removed; the characters * = ' { } , ;
// and backslash are dropped; UTF-8 sequences are copied whole. Each text ends
// with an end marker word (tlast high, no byte) whose tuser[1] reports that
// the output_limit register cut the text short. Throughput is one input word
// per clock in steady state while the receiver takes every word: an 18-byte
// lookahead window retires one head byte per cycle while the next byte is
// written. A word with tlast stops the input while the window drains and the
// end marker is sent. The output register holds a result while the receiver
// stalls, which also stops the window; a two-word input queue decouples the
// source side. Write output_limit (reset 2000) only while no text is in flight.
`default_nettype none
module wiki_markup_stripper (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,      // output_limit
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // in_byte
	input  wire logic         s_axis_tlast,   // in_last
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // out_byte
	output logic [1:0]        m_axis_tuser,   // [0] has_byte, [1] truncated
	output logic              m_axis_tlast    // end_of_text
);
	import wms_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               q_valid;
	logic               q_pop;
	item_t              q_item;

	// Byte limit register; the user must write it only between texts, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	wms_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.s_data(s_axis_tdata), .s_last(s_axis_tlast),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	wms_back u_back (
		.clk(clk), .arst_n(arst_n), .limit(limit_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.m_data(m_axis_tdata), .m_user(m_axis_tuser), .m_last(m_axis_tlast)
	);
endmodule
`default_nettype wire

// ----- rtl/core/wms_front.sv -----
// Input side: accepts words, maps newline to a period and queues them.
`default_nettype none
module wms_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_valid,
	output logic               s_ready,
	input  wire logic [7:0]    s_data,
	input  wire logic          s_last,
	output logic               q_valid,
	output wms_pkg::item_t     q_item,
	input  wire logic          q_pop
);
	import wms_pkg::*;

	item_t       fifo_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  fill_q;
	logic        push;
	item_t       in_item;

	assign s_ready = (fill_q != 2'd2);
	assign push = s_valid && s_ready;
	assign q_valid = (fill_q != 2'd0);
	assign q_item = fifo_q[rd_q];

	always_comb begin
		in_item.data = (s_data == 8'h0A) ? 8'h2E : s_data;
		in_item.last = s_last;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/wms_match.sv -----
// Pattern recognizer: classifies the lookahead window head.
`default_nettype none
module wms_match (
	input  wire wms_pkg::window_t            win,
	input  wire logic [wms_pkg::CNT_W-1:0]   cnt,
	output wms_pkg::match_t                  m
);
	import wms_pkg::*;

	logic [7:0] b;
	logic [2:0] lead_len;
	logic       cont_ok;

	assign b = win[0];

	always_comb begin
		m = '0;
		m.math = head_is(win, cnt, "<math", 5'd5);
		m.font = head_is(win, cnt, "<font", 5'd5) && (cnt < 5'd6 || win[5] != 8'h20);
		m.ref_tag = head_is(win, cnt, "<ref", 5'd4);
		m.cat = head_is(win, cnt, "[[Category:", 5'd11);
		m.div_tag = head_is(win, cnt, "<div", 5'd4) || head_is(win, cnt, "<DIV", 5'd4)
			|| head_is(win, cnt, "</div", 5'd5);
		// Scan backward so the earliest table entry wins.
		for (int i = NLITS - 1; i >= 0; i--) begin
			if (head_is(win, cnt, LIT_STR[i], LIT_LEN[i])) begin
				m.lit = 1'b1;
				m.lit_len = LIT_LEN[i];
			end
		end
		case (b) inside
			8'h2A, 8'h3D, 8'h27, 8'h7B, 8'h7D, 8'h0A, 8'h2C, 8'h3B, 8'h5C: m.drop = 1'b1;
			default: m.drop = 1'b0;
		endcase
		m.close_math = head_is(win, cnt, "</math>", 5'd7);
		m.close_font = head_is(win, cnt, "</font>", 5'd7);
		m.close_cat = head_is(win, cnt, "]]", 5'd2);

		if (b >= 8'hC2 && b <= 8'hDF) lead_len = 3'd2;
		else if (b >= 8'hE0 && b <= 8'hEF) lead_len = 3'd3;
		else if (b >= 8'hF0 && b <= 8'hF4) lead_len = 3'd4;
		else lead_len = 3'd1;
		cont_ok = ({2'b00, lead_len} <= cnt);
		for (int i = 1; i < 4; i++) begin
			if (i < int'(lead_len) && win[i][7:6] != 2'b10) begin
				cont_ok = 1'b0;
			end
		end
		m.utf8_len = cont_ok ? lead_len : 3'd1;
	end
endmodule
`default_nettype wire

// ----- rtl/core/wms_back.sv -----
// Execution side: lookahead window, skip engine and output register.
`default_nettype none
module wms_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [wms_pkg::LIMIT_W-1:0]   limit,
	input  wire logic                          q_valid,
	input  wire wms_pkg::item_t                q_item,
	output logic                               q_pop,
	output logic                               m_valid,
	input  wire logic                          m_ready,
	output logic [7:0]                         m_data,
	output logic [1:0]                         m_user,
	output logic                               m_last
);
	import wms_pkg::*;

	window_t            win_q, win_n;
	logic [CNT_W-1:0]   cnt_q, widx;
	logic [2:0]         mode_q, mode_n;
	logic [DEPTH_W-1:0] depth_q, depth_n;
	logic [CNT_W-1:0]   skip_q, skip_n;
	logic [LIMIT_W-1:0] emit_q, emit_n;
	logic [1:0]         pend_q, pend_n;
	logic               flush_q;
	logic               step_ok, do_pop, do_mark, emit_en;
	logic [7:0]         b;
	match_t             m;

	wms_match u_match (.win(win_q), .cnt(cnt_q), .m(m));

	assign b = win_q[0];
	assign step_ok = !m_valid || m_ready;
	assign do_pop = step_ok && cnt_q != '0 && (flush_q || cnt_q == CNT_W'(LOOKAHEAD));
	assign do_mark = step_ok && flush_q && cnt_q == '0;
	assign q_pop = q_valid && !flush_q && (cnt_q < CNT_W'(LOOKAHEAD) || do_pop);
	assign widx = cnt_q - {{(CNT_W-1){1'b0}}, do_pop};

	always_comb begin
		mode_n = mode_q;
		depth_n = depth_q;
		skip_n = skip_q;
		emit_n = emit_q;
		pend_n = pend_q;
		emit_en = 1'b0;
		if (skip_q != '0) begin
			skip_n = skip_q - 1'b1;
		end else begin
			unique case (mode_q)
				M_NORMAL: begin
					if (pend_q != 2'd0) begin
						emit_en = 1'b1;
						pend_n = pend_q - 1'b1;
					end else if (emit_q >= limit) begin
						mode_n = M_TRUNC;
					end else if (b == 8'h7B) begin
						depth_n = DEPTH_W'(1);
						mode_n = M_BRACE;
					end else if (m.math) begin
						mode_n = M_MATH;
						skip_n = CNT_W'(4);
					end else if (m.font) begin
						mode_n = M_FONT;
						skip_n = CNT_W'(4);
					end else if (m.ref_tag) begin
						mode_n = M_GT;
						skip_n = CNT_W'(3);
					end else if (m.cat) begin
						mode_n = M_CAT;
						skip_n = CNT_W'(10);
					end else if (m.div_tag) begin
						mode_n = M_GT;
						skip_n = CNT_W'(3);
					end else if (m.lit) begin
						skip_n = m.lit_len - 1'b1;
					end else if (m.drop) begin
						mode_n = M_NORMAL;
					end else if (m.utf8_len > 3'd1 &&
							({1'b0, emit_q} + 17'(m.utf8_len)) >= {1'b0, limit}) begin
						mode_n = M_TRUNC;
					end else begin
						emit_en = 1'b1;
						pend_n = 2'(m.utf8_len - 3'd1);
					end
				end
				M_BRACE: begin
					if (b == 8'h7B) begin
						if (depth_q != '1) depth_n = depth_q + 1'b1;
					end else if (b == 8'h7D) begin
						if (depth_q != '0) depth_n = depth_q - 1'b1;
						if (depth_q <= DEPTH_W'(1)) mode_n = M_NORMAL;
					end
				end
				M_MATH: begin
					if (m.close_math) begin
						mode_n = M_NORMAL;
						skip_n = CNT_W'(6);
					end
				end
				M_FONT: begin
					if (m.close_font) begin
						mode_n = M_NORMAL;
						skip_n = CNT_W'(6);
					end
				end
				M_GT: begin
					if (b == 8'h3E) mode_n = M_NORMAL;
				end
				M_CAT: begin
					if (m.close_cat) begin
						mode_n = M_NORMAL;
						skip_n = CNT_W'(1);
					end
				end
				default: mode_n = mode_q;
			endcase
		end
		if (emit_en) emit_n = emit_q + 1'b1;
	end

	always_comb begin
		win_n = win_q;
		if (do_pop) begin
			for (int i = 0; i < LOOKAHEAD - 1; i++) win_n[i] = win_q[i+1];
		end
		if (q_pop) begin
			for (int i = 0; i < LOOKAHEAD; i++) begin
				if (widx == CNT_W'(i)) win_n[i] = q_item.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_n;
		if (do_pop && emit_en) begin
			m_data <= b;
			m_user <= 2'b01;
			m_last <= 1'b0;
		end else if (do_mark) begin
			m_data <= 8'h00;
			m_user <= {mode_q == M_TRUNC, 1'b0};
			m_last <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mode_q <= M_NORMAL;
			depth_q <= '0;
			skip_q <= '0;
			emit_q <= '0;
			pend_q <= '0;
			flush_q <= 1'b0;
			m_valid <= 1'b0;
		end else begin
			cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, do_pop} + {{(CNT_W-1){1'b0}}, q_pop};
			if (do_pop) begin
				mode_q <= mode_n;
				depth_q <= depth_n;
				skip_q <= skip_n;
				emit_q <= emit_n;
				pend_q <= pend_n;
			end
			if (do_mark) begin
				mode_q <= M_NORMAL;
				depth_q <= '0;
				skip_q <= '0;
				emit_q <= '0;
				pend_q <= '0;
				flush_q <= 1'b0;
			end else if (q_pop && q_item.last) begin
				flush_q <= 1'b1;
			end
			if ((do_pop && emit_en) || do_mark) m_valid <= 1'b1;
			else if (m_ready) m_valid <= 1'b0;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LOOKAHEAD)) else $error("window overfilled");
	a_byte_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid && m_user[0] |-> !m_last && !m_user[1]) else $error("byte word flags");
	a_mark_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid && m_last |-> !m_user[0]) else $error("end marker carries a byte");
	a_no_fill_flush: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !q_pop) else $error("fill during flush");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && emit_en && pend_q == 2'd0 |-> emit_q < limit) else $error("limit passed");
endmodule
`default_nettype wire

// ----- dv/tb_wiki_markup_stripper.sv -----
// Self-checking testbench for the wiki markup stripper: random and directed texts against a predictor.
`default_nettype none
module tb_wiki_markup_stripper;
	import wms_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [7:0] data;
		logic has_byte;
		logic eot;
		logic trunc;
	} clean_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	wiki_markup_stripper uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The predictor keeps its own copy of the block's state.
	logic [15:0] limit_q = LIMIT_RESET;
	logic [7:0] win [LOOKAHEAD];
	int win_cnt, mode, depth, skip_left, emitted, utf8_left;

	string lits [NLITS] = '{
		"<ul>", "<li>", "<em>", "</ul>", "</li>", "</em>", "[[", "]]",
		"<small>", "</small>", "<br>", "<br >", "<br />", "<BR>", "<br/>",
		"</br/>", "<br/ >", "<ref>", "</ref>", "<code>", "</code>",
		"<table alignright>", "</table>", "<tt>", "</tt>", "<sup>", "</sup>",
		"<nowiki>", "</nowiki>", "<HR>", "<!--", "-->", "<REF>", "</REF>",
		"<center>", "</center>", "&amp;", "</div>", "</DIV>"
	};

	clean_word_t expected_q[$];
	logic [8:0] pending_q[$];	// {last, byte}

	int mismatches = 0;
	bit failed = 0;
	int accepted_out = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	// Handshakes seen at the last rising edge.
	bit in_fire = 0;
	bit out_fire = 0;

	function automatic bit starts_with(string s);
		for (int i = 0; i < s.len(); i++) begin
			if (i >= win_cnt || i >= LOOKAHEAD) return 0;
			if (win[i] != s[i]) return 0;
		end
		return 1;
	endfunction

	task automatic drop_head();
		if (win_cnt == 0) return;
		for (int i = 0; i < LOOKAHEAD - 1; i++) win[i] = win[i+1];
		win_cnt--;
	endtask

	task automatic push_byte(logic [7:0] b);
		clean_word_t w;
		w = '{data: b, has_byte: 1'b1, eot: 1'b0, trunc: 1'b0};
		expected_q.push_back(w);
		emitted++;
	endtask

	function automatic int seq_len();
		logic [7:0] b;
		int n;
		b = win[0];
		if (b >= 8'hC2 && b <= 8'hDF) n = 2;
		else if (b >= 8'hE0 && b <= 8'hEF) n = 3;
		else if (b >= 8'hF0 && b <= 8'hF4) n = 4;
		else return 1;
		if (n > win_cnt) return 1;
		for (int i = 1; i < n; i++)
			if (win[i][7:6] != 2'b10) return 1;
		return n;
	endfunction

	task automatic start_drop(int m, int n);
		mode = m;
		skip_left = n;
	endtask

	task automatic decide_head();
		logic [7:0] b;
		int n;
		b = win[0];
		if (emitted >= limit_q) begin
			mode = M_TRUNC;
			return;
		end
		if (b == "{") begin
			depth = 1;
			start_drop(M_BRACE, 1);
			return;
		end
		if (starts_with("<math")) begin start_drop(M_MATH, 5); return; end
		if (starts_with("<font") && (win_cnt < 6 || win[5] != " ")) begin
			start_drop(M_FONT, 5);
			return;
		end
		if (starts_with("<ref")) begin start_drop(M_GT, 4); return; end
		if (starts_with("[[Category:")) begin start_drop(M_CAT, 11); return; end
		if (starts_with("<div") || starts_with("<DIV") || starts_with("</div")) begin
			start_drop(M_GT, 4);
			return;
		end
		foreach (lits[i]) begin
			if (starts_with(lits[i])) begin
				start_drop(M_NORMAL, lits[i].len());
				return;
			end
		end
		if (b inside {"*", "=", "'", "{", "}", 8'h0A, ",", ";", 8'h5C}) begin
			drop_head();
			return;
		end
		n = seq_len();
		if (n > 1 && emitted + n >= limit_q) begin
			mode = M_TRUNC;
			return;
		end
		push_byte(b);
		utf8_left = n - 1;
		drop_head();
	endtask

	task automatic retire_head();
		logic [7:0] b;
		b = win[0];
		if (skip_left > 0) begin
			drop_head();
			skip_left--;
			return;
		end
		case (mode)
			M_NORMAL: begin
				if (utf8_left > 0) begin
					push_byte(b);
					utf8_left--;
					drop_head();
				end else begin
					decide_head();
				end
			end
			M_BRACE: begin
				if (b == "{") begin
					if (depth < (1 << DEPTH_W) - 1) depth++;
				end else if (b == "}") begin
					if (depth > 0) depth--;
					if (depth == 0) mode = M_NORMAL;
				end
				drop_head();
			end
			M_MATH: if (starts_with("</math>")) start_drop(M_NORMAL, 7); else drop_head();
			M_FONT: if (starts_with("</font>")) start_drop(M_NORMAL, 7); else drop_head();
			M_GT: begin
				if (b == ">") mode = M_NORMAL;
				drop_head();
			end
			M_CAT: if (starts_with("]]")) start_drop(M_NORMAL, 2); else drop_head();
			default: drop_head();
		endcase
	endtask

	task automatic clear_text();
		win_cnt = 0;
		mode = M_NORMAL;
		depth = 0;
		skip_left = 0;
		emitted = 0;
		utf8_left = 0;
	endtask

	// Predicts every result that one accepted input word causes.
	task automatic predict_word(logic [7:0] b, logic last);
		clean_word_t w;
		if (b == 8'h0A) b = ".";
		if (win_cnt < LOOKAHEAD) begin
			win[win_cnt] = b;
			win_cnt++;
		end
		while (win_cnt > 0 && (last || win_cnt >= LOOKAHEAD)) retire_head();
		if (last) begin
			w = '{data: 8'h00, has_byte: 1'b0, eot: 1'b1, trunc: mode == M_TRUNC};
			expected_q.push_back(w);
			clear_text();
		end
	endtask

	// Driver: presents queued words at falling edges with random gaps.
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				void'(pending_q.pop_front());
				send_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end
			if (!s_axis_tvalid || in_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					{s_axis_tlast, s_axis_tdata} <= pending_q[0];
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver readiness: random stalls plus one long hold-off on request.
	int recv_gap = 0;
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (out_fire) recv_gap = $urandom_range(0, 5);
		end
	end

	// Input monitor feeds the predictor; output monitor checks results.
	always @(posedge clk) begin
		clean_word_t got, exp_w;
		in_fire = s_axis_tvalid && s_axis_tready;
		out_fire = m_axis_tvalid && m_axis_tready;
		if (in_fire) predict_word(s_axis_tdata, s_axis_tlast);
		if (in_fire || out_fire)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (out_fire) begin
			got = '{data: m_axis_tdata, has_byte: m_axis_tuser[0], eot: m_axis_tlast,
				trunc: m_axis_tuser[1]};
			accepted_out++;
			if (expected_q.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", got);
			end else begin
				exp_w = expected_q.pop_front();
				if (got !== exp_w) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected byte %h has %b eot %b trunc %b, got byte %h has %b eot %b trunc %b",
							exp_w.data, exp_w.has_byte, exp_w.eot, exp_w.trunc,
							got.data, got.has_byte, got.eot, got.trunc);
				end
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_wiki_markup_stripper: errors");
			$finish;
		end
	end

	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			pending_q.push_back({i == s.len() - 1, s[i]});
	endtask

	task automatic queue_random_text(int n);
		string frags [14] = '{"{{x|{y}}}", "<math>a</math>", "<font c>q</font>", "<ref n>",
			"[[Category:Z]]", "<div a>", "&amp;", "<br />", "*=',;", "\xC3\xA9",
			"\xE2\x82\xAC", "\xF0\x9F\x98\x80", "<!--", "\n"};
		string s;
		int k;
		s = "";
		while (s.len() < n) begin
			k = $urandom_range(0, 3);
			if (k == 0) s = {s, frags[$urandom_range(0, 13)]};
			else if (k == 1) s = {s, string'(8'($urandom_range(1, 255)))};
			else s = {s, string'(8'($urandom_range(8'h61, 8'h7A)))};
		end
		if ($urandom_range(0, 1)) s = {s, string'(8'($urandom_range(1, 255)))};
		queue_text(s);
	endtask

	task automatic wait_idle();
		while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		limit_q = v;
	endtask

	initial begin
		clear_text();
		foreach (win[i]) win[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Directed texts under the reset limit: each kind of construct and several special cases.
		queue_text("{x{}}a<math>m</math><font>y</font>");
		queue_text("<ref n>[[Category:K]]<div>&amp;*=,\\\nc<font");
		queue_text("\xC3\xA9\xC3z\xE2\x82\xAC\xF0\x9F\x98\x80{{}");
		wait_idle();
		write_limit(16'd1);
		queue_text("ab\xC3\xA9");
		queue_text("\xC3\xA9c");
		wait_idle();
		write_limit(16'd0);
		queue_text("xyz");
		wait_idle();
		write_limit(16'd5);
		queue_random_text($urandom_range(3, 6));
		wait_idle();
		write_limit(16'hFFFF);
		// Long receiver hold-off while texts keep coming.
		hold_off = 200;
		for (int t = 0; t < 2; t++) queue_random_text($urandom_range(3, 6));
		wait_idle();
		if (failed || expected_q.size() > 0) begin
			$display("tb_wiki_markup_stripper: errors");
		end else begin
			$display("tb_wiki_markup_stripper: clean");
		end
		$finish;
	end

endmodule
`default_nettype wire
